[sv/fmsc_pkg.sv]
// Shared types, constants and the signature table of the file signature classifier.
`timescale 1ns / 1ps

package fmsc_pkg;

    // Number of leading bytes that any signature looks at.
    localparam int SIG_LEN = 12;

    // Default for the saturation point of the byte count.
    localparam int STORED_BYTES_DEF = 12;

    // Byte count as seen by the classifier, clamped to SIG_LEN.
    localparam int CNT_W = $clog2(SIG_LEN + 1);

    // Signature rows and the row index used by the scan.
    localparam int ROW_COUNT = 43;
    localparam int ROW_W = $clog2(ROW_COUNT);

    // Entries in the queue between the byte collector and the scanner.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CODE_W = 6;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = '0;

    // Header bytes, byte 0 is the first byte of the file.
    typedef logic [0:SIG_LEN-1][7:0] sig_bytes_t;

    // One file handed from the collector to the scanner.
    typedef struct packed {
        sig_bytes_t           hdr;
        logic [CNT_W-1:0]     cnt;
    } hdr_entry_t;

    // One row of the signature table; care bit i selects byte i for comparison.
    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [CNT_W-1:0]     min_bytes;
        logic [SIG_LEN-1:0]   care;
        sig_bytes_t           pat;
    } sig_row_t;

    // Signature table in priority order.
    function automatic sig_row_t sig_row(input logic [ROW_W-1:0] idx);
        sig_row_t r;
        unique case (idx)
            6'd0:  r = {6'd1,  4'd4,  12'h00F, 96'h504B0304_00000000_00000000};
            6'd1:  r = {6'd2,  4'd6,  12'h03F, 96'h377ABCAF_271C0000_00000000};
            6'd2:  r = {6'd3,  4'd7,  12'h07F, 96'h52617221_1A070000_00000000};
            6'd3:  r = {6'd4,  4'd7,  12'h07F, 96'h52617221_1A070100_00000000};
            6'd4:  r = {6'd5,  4'd2,  12'h003, 96'h1F8B0000_00000000_00000000};
            6'd5:  r = {6'd6,  4'd4,  12'h00F, 96'h4D534346_00000000_00000000};
            6'd6:  r = {6'd7,  4'd4,  12'h00F, 96'h78617221_00000000_00000000};
            6'd7:  r = {6'd8,  4'd6,  12'h03F, 96'h30373037_30370000_00000000};
            6'd8:  r = {6'd8,  4'd6,  12'h03F, 96'h30373037_30310000_00000000};
            6'd9:  r = {6'd9,  4'd7,  12'h04C, 96'h00002D6C_00002D00_00000000};
            6'd10: r = {6'd10, 4'd8,  12'h0FF, 96'h213C6172_63683E0A_00000000};
            6'd11: r = {6'd11, 4'd8,  12'h0FF, 96'h636F6E65_63746978_00000000};
            6'd12: r = {6'd12, 4'd4,  12'h00F, 96'h4B444D56_00000000_00000000};
            6'd13: r = {6'd13, 4'd4,  12'h00F, 96'h514649FB_00000000_00000000};
            6'd14: r = {6'd14, 4'd5,  12'h00F, 96'h4E455235_00000000_00000000};
            6'd15: r = {6'd14, 4'd5,  12'h01F, 96'h4E65726F_35000000_00000000};
            6'd16: r = {6'd15, 4'd3,  12'h007, 96'h444F5300_00000000_00000000};
            6'd17: r = {6'd16, 4'd4,  12'h00F, 96'h49574144_00000000_00000000};
            6'd18: r = {6'd16, 4'd4,  12'h00F, 96'h50574144_00000000_00000000};
            6'd19: r = {6'd16, 4'd4,  12'h00F, 96'h57414432_00000000_00000000};
            6'd20: r = {6'd16, 4'd4,  12'h00F, 96'h57414433_00000000_00000000};
            6'd21: r = {6'd17, 4'd4,  12'h00F, 96'h5041434B_00000000_00000000};
            6'd22: r = {6'd18, 4'd12, 12'hFFF, 96'h4B656E53_696C7665_726D616E};
            6'd23: r = {6'd19, 4'd4,  12'h00F, 96'h484F47F0_00000000_00000000};
            6'd24: r = {6'd20, 4'd4,  12'h00F, 96'h3412AA55_00000000_00000000};
            6'd25: r = {6'd21, 4'd4,  12'h00F, 96'h4D50511A_00000000_00000000};
            6'd26: r = {6'd22, 4'd6,  12'h03F, 96'hFD377A58_5A000000_00000000};
            6'd27: r = {6'd23, 4'd4,  12'h00F, 96'h28B52FFD_00000000_00000000};
            6'd28: r = {6'd24, 4'd4,  12'h00F, 96'h04224D18_00000000_00000000};
            6'd29: r = {6'd25, 4'd3,  12'h007, 96'h425A6800_00000000_00000000};
            6'd30: r = {6'd26, 4'd4,  12'h00F, 96'h474F4220_00000000_00000000};
            6'd31: r = {6'd27, 4'd4,  12'h00F, 96'h5246461A_00000000_00000000};
            6'd32: r = {6'd28, 4'd4,  12'h00F, 96'h42494746_00000000_00000000};
            6'd33: r = {6'd28, 4'd4,  12'h00F, 96'h42494734_00000000_00000000};
            6'd34: r = {6'd29, 4'd4,  12'h00F, 96'h504F4431_00000000_00000000};
            6'd35: r = {6'd29, 4'd4,  12'h00F, 96'h504F4432_00000000_00000000};
            6'd36: r = {6'd29, 4'd4,  12'h00F, 96'h504F4433_00000000_00000000};
            6'd37: r = {6'd29, 4'd4,  12'h00F, 96'h504F4435_00000000_00000000};
            6'd38: r = {6'd30, 4'd8,  12'h0FF, 96'h4D436F6D_70724844_00000000};
            6'd39: r = {6'd31, 4'd8,  12'h0FF, 96'h4D56202D_20435043_00000000};
            6'd40: r = {6'd31, 4'd8,  12'h0FF, 96'h45585445_4E444544_00000000};
            6'd41: r = {6'd31, 4'd4,  12'h00F, 96'h32494D47_00000000_00000000};
            6'd42: r = {6'd32, 4'd12, 12'hFFF, 96'h00FFFFFF_FFFFFFFF_FFFFFF00};
            // Unused row indexes never match: their minimum exceeds any count.
            default: r = {CODE_UNKNOWN, {CNT_W{1'b1}}, {SIG_LEN{1'b0}}, {(8*SIG_LEN){1'b0}}};
        endcase
        return r;
    endfunction

    // True when the header and byte count satisfy the given row.
    function automatic logic row_hit(input sig_row_t r, input sig_bytes_t hdr,
                                     input logic [CNT_W-1:0] cnt);
        logic ok;
        ok = (cnt >= r.min_bytes);
        for (int i = 0; i < SIG_LEN; i++) begin
            if (r.care[i] && (hdr[i] != r.pat[i])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

[sv/fmsc_front.sv]
// Byte collector: stores the header bytes and hands each finished file to the queue.
`timescale 1ns / 1ps

module fmsc_front
    import fmsc_pkg::*;
#(
    parameter int STORED_BYTES = STORED_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_item,
    output logic        push_valid,
    input  logic        push_stall,
    output hdr_entry_t  push_data
);

    localparam int CW = $clog2(STORED_BYTES + 1);

    sig_bytes_t      hdr_reg;
    sig_bytes_t      hdr_snap;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [CW-1:0]   cnt_inc;
    logic            accept;
    logic            wr_en;

    // The whole input waits while the queue is full.
    assign in_stall = push_stall;
    assign accept   = in_valid && !in_stall;
    assign wr_en    = accept && has_byte && (cnt_reg < CW'(STORED_BYTES));
    assign cnt_inc  = cnt_reg + CW'(wr_en);

    // Header as it stands after this transaction, including a byte that arrives with last.
    always_comb
    begin
        hdr_snap = hdr_reg;
        for (int i = 0; i < SIG_LEN; i++) begin
            if (wr_en && (cnt_reg == CW'(i))) begin
                hdr_snap[i] = data_byte;
            end
        end
    end

    // The count restarts after a file is handed over.
    always_comb
    begin
        if (accept && last_item) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt_inc;
        end
    end

    // The classifier never needs more than SIG_LEN, so the count it sees is clamped.
    always_comb
    begin
        push_valid    = accept && last_item;
        push_data.hdr = hdr_snap;
        if (cnt_inc >= CW'(SIG_LEN)) begin
            push_data.cnt = CNT_W'(SIG_LEN);
        end else begin
            push_data.cnt = CNT_W'(cnt_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Bytes beyond the signature length are never compared, so not kept; the count saturates at STORED_BYTES.
    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_snap;
    end

endmodule

[sv/fmsc_queue.sv]
// Short queue of finished file headers between the collector and the scanner.
`timescale 1ns / 1ps

module fmsc_queue
    import fmsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_stall,
    input  hdr_entry_t  push_data,
    output logic        pop_valid,
    input  logic        pop_stall,
    output hdr_entry_t  pop_data
);

    hdr_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   fill_reg;
    logic                push;
    logic                pop;

    assign push_stall = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/fmsc_back.sv]
// Signature scanner: walks the table one row per cycle and registers the type code.
`timescale 1ns / 1ps

module fmsc_back
    import fmsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_stall,
    input  hdr_entry_t         pop_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CODE_W-1:0]  type_code
);

    hdr_entry_t          work_reg;
    logic                busy_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                out_valid_reg;
    logic [CODE_W-1:0]   code_reg;
    sig_row_t            cur_row;
    logic                hit;
    logic                done;
    logic                out_free;
    logic                finish;
    logic                load;

    assign cur_row  = sig_row(row_reg);
    assign hit      = row_hit(cur_row, work_reg.hdr, work_reg.cnt);
    assign done     = busy_reg && (hit || (row_reg == ROW_W'(ROW_COUNT - 1)));
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = done && out_free;
    assign pop_stall = busy_reg;
    assign load     = pop_valid && !busy_reg;

    assign out_valid = out_valid_reg;
    assign type_code = code_reg;

    // Scan control and output register handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                row_reg  <= '0;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end else if (busy_reg && !done) begin
                row_reg <= row_reg + 1'b1;
            end

            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Header under test and the result code.
    always_ff @(posedge clk)
    begin
        if (load) begin
            work_reg <= pop_data;
        end
        if (finish) begin
            code_reg <= hit ? cur_row.code : CODE_UNKNOWN;
        end
    end

endmodule

[sv/file_magic_signature_classifier_core.sv]
// Top level of the file signature classifier.
`timescale 1ns / 1ps

// Header bytes are taken one per cycle and stored; the transaction that carries last_item
// hands the header to a two-entry queue, and the scanner compares it against the 43-row
// signature table, one row per cycle; the first matching row gives the type code, 0 means
// unknown. Input is stalled only while the queue is full, so byte transactions keep
// streaming at one per cycle while earlier files are still being scanned.

module file_magic_signature_classifier_core
    import fmsc_pkg::*;
#(
    parameter int STORED_BYTES = STORED_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               has_byte,
    input  logic               last_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CODE_W-1:0]  type_code
);

    logic        push_valid;
    logic        push_stall;
    hdr_entry_t  push_data;
    logic        pop_valid;
    logic        pop_stall;
    hdr_entry_t  pop_data;

    fmsc_front #(
        .STORED_BYTES (STORED_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last_item  (last_item),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_data  (push_data)
    );

    fmsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_data   (pop_data)
    );

    fmsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .type_code  (type_code)
    );

endmodule

[tb/file_magic_signature_classifier_core_tb.sv]
// Self-checking testbench for the file signature classifier core.
`timescale 1ns / 1ps

module file_magic_signature_classifier_core_tb;
    import fmsc_pkg::*;

    localparam int HDR_BYTES = 12;
    localparam int N_SIGS = 43;
    localparam int TARGET_ITEMS = 1650;
    localparam int CYCLE_LIMIT = 800000;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 60;

    // Marker for directed rows whose type code comes from the predictor.
    localparam int WANT_PREDICTED = -1;

    // Type codes quoted in the directed table.
    localparam logic [CODE_W-1:0] TYPE_GZIP  = 6'd5;
    localparam logic [CODE_W-1:0] TYPE_BZIP2 = 6'd25;
    localparam logic [CODE_W-1:0] TYPE_CDI   = 6'd32;

    // One signature: bytes flagged in care must equal pat, byte 0 leftmost.
    typedef struct packed {
        logic [CODE_W-1:0]     code;
        logic [3:0]            min_count;
        logic [HDR_BYTES-1:0]  care;
        logic [0:11][7:0]      pat;
    } signature_t;

    // One directed transaction.
    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       last;
        int         want;
    } directed_t;

    signature_t sig_tab [N_SIGS] = '{
        {6'd1,  4'd4,  12'h00F, 96'h504B0304_00000000_00000000},
        {6'd2,  4'd6,  12'h03F, 96'h377ABCAF_271C0000_00000000},
        {6'd3,  4'd7,  12'h07F, 96'h52617221_1A070000_00000000},
        {6'd4,  4'd7,  12'h07F, 96'h52617221_1A070100_00000000},
        {6'd5,  4'd2,  12'h003, 96'h1F8B0000_00000000_00000000},
        {6'd6,  4'd4,  12'h00F, 96'h4D534346_00000000_00000000},
        {6'd7,  4'd4,  12'h00F, 96'h78617221_00000000_00000000},
        {6'd8,  4'd6,  12'h03F, 96'h30373037_30370000_00000000},
        {6'd8,  4'd6,  12'h03F, 96'h30373037_30310000_00000000},
        {6'd9,  4'd7,  12'h04C, 96'h00002D6C_00002D00_00000000},
        {6'd10, 4'd8,  12'h0FF, 96'h213C6172_63683E0A_00000000},
        {6'd11, 4'd8,  12'h0FF, 96'h636F6E65_63746978_00000000},
        {6'd12, 4'd4,  12'h00F, 96'h4B444D56_00000000_00000000},
        {6'd13, 4'd4,  12'h00F, 96'h514649FB_00000000_00000000},
        {6'd14, 4'd5,  12'h00F, 96'h4E455235_00000000_00000000},
        {6'd14, 4'd5,  12'h01F, 96'h4E65726F_35000000_00000000},
        {6'd15, 4'd3,  12'h007, 96'h444F5300_00000000_00000000},
        {6'd16, 4'd4,  12'h00F, 96'h49574144_00000000_00000000},
        {6'd16, 4'd4,  12'h00F, 96'h50574144_00000000_00000000},
        {6'd16, 4'd4,  12'h00F, 96'h57414432_00000000_00000000},
        {6'd16, 4'd4,  12'h00F, 96'h57414433_00000000_00000000},
        {6'd17, 4'd4,  12'h00F, 96'h5041434B_00000000_00000000},
        {6'd18, 4'd12, 12'hFFF, 96'h4B656E53_696C7665_726D616E},
        {6'd19, 4'd4,  12'h00F, 96'h484F47F0_00000000_00000000},
        {6'd20, 4'd4,  12'h00F, 96'h3412AA55_00000000_00000000},
        {6'd21, 4'd4,  12'h00F, 96'h4D50511A_00000000_00000000},
        {6'd22, 4'd6,  12'h03F, 96'hFD377A58_5A000000_00000000},
        {6'd23, 4'd4,  12'h00F, 96'h28B52FFD_00000000_00000000},
        {6'd24, 4'd4,  12'h00F, 96'h04224D18_00000000_00000000},
        {6'd25, 4'd3,  12'h007, 96'h425A6800_00000000_00000000},
        {6'd26, 4'd4,  12'h00F, 96'h474F4220_00000000_00000000},
        {6'd27, 4'd4,  12'h00F, 96'h5246461A_00000000_00000000},
        {6'd28, 4'd4,  12'h00F, 96'h42494746_00000000_00000000},
        {6'd28, 4'd4,  12'h00F, 96'h42494734_00000000_00000000},
        {6'd29, 4'd4,  12'h00F, 96'h504F4431_00000000_00000000},
        {6'd29, 4'd4,  12'h00F, 96'h504F4432_00000000_00000000},
        {6'd29, 4'd4,  12'h00F, 96'h504F4433_00000000_00000000},
        {6'd29, 4'd4,  12'h00F, 96'h504F4435_00000000_00000000},
        {6'd30, 4'd8,  12'h0FF, 96'h4D436F6D_70724844_00000000},
        {6'd31, 4'd8,  12'h0FF, 96'h4D56202D_20435043_00000000},
        {6'd31, 4'd8,  12'h0FF, 96'h45585445_4E444544_00000000},
        {6'd31, 4'd4,  12'h00F, 96'h32494D47_00000000_00000000},
        {6'd32, 4'd12, 12'hFFF, 96'h00FFFFFF_FFFFFFFF_FFFFFF00}
    };

    // Directed files: empty, gzip closed by its last byte, extremes ended
    // with an end-only transaction, bzip2, and a full store plus one byte.
    directed_t directed_tab [24] = '{
        '{8'h00, 1'b0, 1'b1, CODE_UNKNOWN},
        '{8'hA5, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h1F, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'h8B, 1'b1, 1'b1, TYPE_GZIP},
        '{8'h00, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b0, 1'b1, CODE_UNKNOWN},
        '{8'h42, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'h5A, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'h68, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'h00, 1'b0, 1'b1, TYPE_BZIP2},
        '{8'h00, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'h00, 1'b1, 1'b0, WANT_PREDICTED},
        '{8'h55, 1'b1, 1'b1, TYPE_CDI}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               has_byte;
    logic               last_item;
    logic               out_valid;
    logic               out_stall;
    logic [CODE_W-1:0]  type_code;

    // Predictor state: stored header bytes and the saturating byte count.
    logic [7:0]         hdr_copy [HDR_BYTES];
    int                 hdr_count;

    logic [CODE_W-1:0]  expected_codes [$];
    logic [N_SIGS-1:0]  rows_aimed;
    int                 errors;
    int                 items_sent;
    int                 idle_sent;
    int                 codes_checked;
    int                 cycles;
    logic               quiet;
    logic               hold_request;

    file_magic_signature_classifier_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last_item (last_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .type_code (type_code)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Type code of the first signature that the stored header satisfies.
    function automatic logic [CODE_W-1:0] classify_header();
        logic [CODE_W-1:0] found;
        logic              hit;
        logic              done;
        done = 1'b0;
        found = CODE_UNKNOWN;
        for (int k = 0; k < N_SIGS; k++) begin
            hit = !done && (hdr_count >= sig_tab[k].min_count);
            for (int i = 0; i < HDR_BYTES; i++) begin
                if (hit && sig_tab[k].care[i] && hdr_copy[i] != sig_tab[k].pat[i]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                found = sig_tab[k].code;
                done = 1'b1;
            end
        end
        return found;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Offer one transaction, wait for its acceptance and update the predictor.
    task automatic send_item(input logic [7:0] b, input logic h, input logic l,
                             input int want);
        logic stalled;
        logic [CODE_W-1:0] code;
        while (!quiet && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= h;
        last_item <= l;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        if (h || l) begin
            items_sent++;
        end else begin
            idle_sent++;
        end
        if (h && hdr_count < HDR_BYTES) begin
            hdr_copy[hdr_count] = b;
            hdr_count++;
        end
        if (l) begin
            code = classify_header();
            expected_codes.push_back((want == WANT_PREDICTED) ? code : want[CODE_W-1:0]);
            hdr_count = 0;
        end
    endtask

    // One random file: mostly a signature with random filler, some broken
    // signatures, and some plain noise.
    task automatic send_random_file();
        logic [7:0] file_bytes [$];
        int kind;
        int r;
        int n;
        int pos;
        logic [7:0] v;
        kind = $urandom_range(99);
        r = $urandom_range(N_SIGS - 1);
        if (kind < 80) begin
            n = sig_tab[r].min_count + $urandom_range(0, 3);
            if ($urandom_range(7) == 0) begin
                n = $urandom_range(sig_tab[r].min_count, 18);
            end
            for (int i = 0; i < n; i++) begin
                v = 8'($urandom);
                if (i < HDR_BYTES && sig_tab[r].care[i]) begin
                    v = sig_tab[r].pat[i];
                end
                file_bytes.push_back(v);
            end
            if (kind < 65) begin
                rows_aimed[r] = 1'b1;
            end else if ($urandom_range(1) == 0) begin
                // Truncated signature: fewer bytes than the row needs.
                while (file_bytes.size() >= sig_tab[r].min_count) begin
                    void'(file_bytes.pop_back());
                end
                while (file_bytes.size() > 0 && $urandom_range(1) == 0) begin
                    void'(file_bytes.pop_back());
                end
            end else begin
                // Corrupt one byte that the row compares.
                do begin
                    pos = $urandom_range(HDR_BYTES - 1);
                end while (!sig_tab[r].care[pos]);
                file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
            end
        end else begin
            n = $urandom_range(0, 15);
            for (int i = 0; i < n; i++) begin
                file_bytes.push_back(8'($urandom));
            end
        end

        n = file_bytes.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0, WANT_PREDICTED);
            end
            send_item(file_bytes[i], 1'b1,
                      (i == n - 1) && (kind[0] == 1'b1), WANT_PREDICTED);
        end
        if (n == 0 || kind[0] == 1'b0) begin
            send_item(8'($urandom), 1'b0, 1'b1, WANT_PREDICTED);
        end
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (quiet) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 30);
            end
        end
    end

    // Result checker, sampled mid-cycle where every signal has settled.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            codes_checked++;
            if (expected_codes.size() == 0) begin
                note_error($sformatf("result with no file pending: type_code %0d",
                                     type_code));
            end else if (type_code !== expected_codes[0]) begin
                note_error($sformatf("type_code mismatch: expected %0d, got %0d",
                                     expected_codes[0], type_code));
                void'(expected_codes.pop_front());
            end else begin
                void'(expected_codes.pop_front());
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycles, expected_codes.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence: reset, directed files, random files, drain.
    initial
    begin
        logic hold_done;
        logic drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        errors = 0;
        items_sent = 0;
        idle_sent = 0;
        codes_checked = 0;
        hdr_count = 0;
        rows_aimed = '0;
        quiet = 1'b0;
        hold_request = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= 8'h00;
        has_byte <= 1'b0;
        last_item <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (directed_tab[i]) begin
            send_item(directed_tab[i].data, directed_tab[i].has,
                      directed_tab[i].last, directed_tab[i].want);
        end

        // Random part with a long output hold, a calm stretch and a full drain.
        while (items_sent < TARGET_ITEMS) begin
            if (!hold_done && items_sent > 300) begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            quiet = (items_sent > 700 && items_sent < 1000);
            if (!drain_done && items_sent > 1300) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (expected_codes.size() != 0) begin
                    @(posedge clk);
                end
                drain_done = 1'b1;
            end
            send_random_file();
        end
        quiet = 1'b0;
        in_valid <= 1'b0;
        has_byte <= 1'b0;
        last_item <= 1'b0;

        // Let the last files finish scanning.
        while (expected_codes.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d byte/end transactions, %0d idle ones, %0d type codes checked.",
                 items_sent, idle_sent, codes_checked);
        $display("Signature rows aimed at with well-formed headers: %0d of %0d.",
                 $countones(rows_aimed), N_SIGS);
        if (errors == 0 && expected_codes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches counted", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[file_magic_signature_classifier_core.f]
sv/fmsc_pkg.sv
sv/fmsc_front.sv
sv/fmsc_queue.sv
sv/fmsc_back.sv
sv/file_magic_signature_classifier_core.sv
tb/file_magic_signature_classifier_core_tb.sv
